// ===== rtl/date_interval_days_macros.svh =====
// assertion macros for the date interval block
// no dependencies; included by files that carry concurrent checks
`ifndef DATE_INTERVAL_DAYS_MACROS_SVH
`define DATE_INTERVAL_DAYS_MACROS_SVH

`ifndef NO_ASSERTIONS

`define DID_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("date_interval_days: check failed");

`define DID_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("date_interval_days: check failed");

`else

`define DID_ASSERT_IMPL(lbl, ck, rn, ante, cons)

`define DID_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

// ===== rtl/did_pkg.sv =====
// types, constants and month tables for the date interval block
// no dependencies; used by the channel interfaces and the top level
package did_pkg;

    localparam int YEAR_W = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W = 5;
    localparam int DIFF_W = 23;

    localparam logic [8:0] YEAR_DAYS = 9'd365;
    localparam logic [6:0] CENTURY = 7'd100;
    localparam logic [3:0] MONTHS = 4'd12;
    localparam logic [3:0] FEB = 4'd1;
    localparam logic [4:0] FEB_LEAP_LEN = 5'd29;

    // floor(y / 100) = (y * RECIP_100) >> RECIP_SHIFT, exact for 14-bit y
    localparam logic [14:0] RECIP_100 = 15'd20972;
    localparam int RECIP_SHIFT = 21;
    localparam int RECIP_PROD_W = 29;

    localparam logic signed [DIFF_W-1:0] DIFF_MAX = 23'sh3FFFFF;
    localparam logic signed [DIFF_W-1:0] DIFF_MIN = 23'sh400000;

    localparam logic [4:0] LEN_COMMON [0:11] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    localparam logic [8:0] CUM_COMMON [0:11] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [22:0]       y365;
        logic [7:0]        q100;
        logic [3:0]        mi;
        logic [DAY_W-1:0]  day;
    } s1_date_t;

    typedef struct packed {
        logic [22:0]      y365;
        logic [11:0]      leaps;
        logic [8:0]       cum;
        logic [DAY_W-1:0] day;
    } s2_date_t;

endpackage

// ===== rtl/did_channels.sv =====
// valid/ready channel interfaces for date pairs and day differences
// depends on did_pkg for field widths
interface did_in_if import did_pkg::*;;
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  year_a;
    logic [MONTH_W-1:0] month_a;
    logic [DAY_W-1:0]   day_a;
    logic [YEAR_W-1:0]  year_b;
    logic [MONTH_W-1:0] month_b;
    logic [DAY_W-1:0]   day_b;

    modport source (
        output valid, year_a, month_a, day_a, year_b, month_b, day_b,
        input  ready
    );
    modport sink (
        input  valid, year_a, month_a, day_a, year_b, month_b, day_b,
        output ready
    );
endinterface

interface did_out_if import did_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DIFF_W-1:0] day_difference;

    modport source (output valid, day_difference, input ready);
    modport sink (input valid, day_difference, output ready);
endinterface

// ===== rtl/date_interval_days.sv =====
// signed day count between two gregorian dates, four-stage pipeline
// depends on did_pkg, did_channels and date_interval_days_macros.svh
//
//  channel   dir  word
//  dates     in   year_a, month_a, day_a, year_b, month_b, day_b
//  result    out  day_difference
//
// one date pair accepted per cycle while result is not stalled; each result
// passes through the reciprocal multiply for the century count, the leap and
// table stage, the day number sum and the subtract with saturation, in that
// order. a stall on result holds every stage in place.
// reset clears the valid bits only; no clearing pass is needed.
`include "date_interval_days_macros.svh"

module date_interval_days
    import did_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    did_in_if.sink     dates,
    did_out_if.source  result
);

    logic advance;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;

    logic [YEAR_W-1:0]  yr_in  [2];
    logic [MONTH_W-1:0] mon_in [2];
    logic [DAY_W-1:0]   day_in [2];
    logic [3:0]         mon_adj [2];
    logic [3:0]         mon_m1  [2];
    logic [RECIP_PROD_W-1:0] q_prod [2];

    s1_date_t s1_next [2];
    s1_date_t s1_reg  [2];

    logic [14:0] rem      [2];
    logic        cent     [2];
    logic        leap     [2];
    logic [13:0] year_m1  [2];
    logic [7:0]  pq100    [2];
    logic [12:0] leap_sum [2];
    logic [4:0]  mlen     [2];

    s2_date_t s2_next [2];
    s2_date_t s2_reg  [2];

    logic signed [23:0] s3_next [2];
    logic signed [23:0] s3_reg  [2];

    logic signed [24:0]       diff;
    logic signed [DIFF_W-1:0] out_next;
    logic signed [DIFF_W-1:0] out_reg;

    assign advance      = !out_valid_reg || result.ready;
    assign dates.ready  = advance;
    assign result.valid = out_valid_reg;
    assign result.day_difference = out_reg;

    // stage 1: month wrap, year times 365, century reciprocal product
    always_comb
    begin
        yr_in[0]  = dates.year_a;
        mon_in[0] = dates.month_a;
        day_in[0] = dates.day_a;
        yr_in[1]  = dates.year_b;
        mon_in[1] = dates.month_b;
        day_in[1] = dates.day_b;
        for (int i = 0; i < 2; i++)
        begin
            mon_adj[i] = (mon_in[i] == 4'd0) ? 4'd1 : mon_in[i];
            mon_m1[i]  = mon_adj[i] - 4'd1;
            q_prod[i]  = RECIP_PROD_W'(yr_in[i]) * RECIP_PROD_W'(RECIP_100);
            s1_next[i].year = yr_in[i];
            s1_next[i].y365 = 23'(yr_in[i]) * 23'(YEAR_DAYS);
            s1_next[i].q100 = q_prod[i][RECIP_SHIFT +: 8];
            s1_next[i].mi   = (mon_m1[i] >= MONTHS) ? mon_m1[i] - MONTHS : mon_m1[i];
            s1_next[i].day  = day_in[i];
        end
    end

    // stage 2: leap flag, leap days before the year, day wrap, month offset
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            rem[i]  = 15'(s1_reg[i].year) - 15'(s1_reg[i].q100) * 15'(CENTURY);
            cent[i] = (rem[i] == 15'd0);
            leap[i] = cent[i] ? (s1_reg[i].q100[1:0] == 2'd0)
                              : (s1_reg[i].year[1:0] == 2'd0);
            year_m1[i]  = s1_reg[i].year - 14'd1;
            pq100[i]    = s1_reg[i].q100 - {7'd0, cent[i]};
            leap_sum[i] = 13'(year_m1[i][13:2]) - 13'(pq100[i]) + 13'(pq100[i][7:2]);
            mlen[i] = (leap[i] && s1_reg[i].mi == FEB) ? FEB_LEAP_LEN
                                                        : LEN_COMMON[s1_reg[i].mi];
            s2_next[i].y365  = s1_reg[i].y365;
            s2_next[i].leaps = (s1_reg[i].year == '0) ? 12'd0 : leap_sum[i][11:0];
            s2_next[i].cum   = CUM_COMMON[s1_reg[i].mi]
                             + {8'd0, leap[i] && (s1_reg[i].mi > FEB)};
            s2_next[i].day   = (s1_reg[i].day > mlen[i]) ? s1_reg[i].day - mlen[i]
                                                         : s1_reg[i].day;
        end
    end

    // stage 3: day number of each date
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            s3_next[i] = $signed(24'(s2_reg[i].y365) + 24'(s2_reg[i].leaps)
                       + 24'(s2_reg[i].cum) + 24'(s2_reg[i].day) - 24'd1);
        end
    end

    // stage 4: difference with saturation
    always_comb
    begin
        diff = 25'(s3_reg[1]) - 25'(s3_reg[0]);
        priority if (diff > 25'(DIFF_MAX))
            out_next = DIFF_MAX;
        else if (diff < 25'(DIFF_MIN))
            out_next = DIFF_MIN;
        else
            out_next = diff[DIFF_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= dates.valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            out_reg <= out_next;
        end
    end

    `DID_ASSERT_NEXT(a_accept_enters, clk, rst_n, dates.valid && dates.ready, s1_valid_reg)
    `DID_ASSERT_IMPL(a_month_wrapped, clk, rst_n, s1_valid_reg, (s1_reg[0].mi < MONTHS) && (s1_reg[1].mi < MONTHS))
    `DID_ASSERT_IMPL(a_century_exact, clk, rst_n, s1_valid_reg, (rem[0] < 15'(CENTURY)) && (rem[1] < 15'(CENTURY)))
    `DID_ASSERT_NEXT(a_stall_holds, clk, rst_n, s3_valid_reg && !advance, s3_valid_reg && $stable(s3_reg[0]) && $stable(s3_reg[1]))

endmodule
